// File: src/ukst_pkg.sv
package ukst_pkg;

    // Operation codes
    localparam logic [1:0] OP_ASSIGN = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_FIND   = 2'd2;
    localparam logic [1:0] OP_SET    = 2'd3;

    // Key held by an empty slot after reset, and the reset no-tool code
    localparam logic [7:0] KEY_RESET = 8'hFF;

    // Saturation limit of the reported occupancy count
    localparam logic [4:0] COUNT_MAX = 5'd15;

    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  slot;
        logic [7:0]  tool_key;
        logic [15:0] target_temp;
    } ukst_in_t;

    typedef struct packed {
        logic        ok;
        logic [3:0]  slot_index;
        logic        slot_occupied;
        logic [7:0]  slot_key;
        logic [15:0] slot_target;
        logic [3:0]  occupied_count;
    } ukst_out_t;

    // Operation token handed from cell to cell
    typedef struct packed {
        logic [1:0]  op;
        logic [3:0]  slot;
        logic [7:0]  key;
        logic [15:0] target;
        logic        in_range;
        logic        found;
        logic [3:0]  where_idx;
        logic        socc;
        logic [7:0]  skey;
        logic [15:0] stgt;
        logic [4:0]  count;
    } ukst_tok_t;

endpackage

// File: src/unique_key_slot_table.sv
// Channel    Ports                     Transfer
// ---------  ------------------------  ------------------------------------
// command    start, busy, cmd          rising edge with start high, busy low
// result     done, result              rising edge ending the cycle done is high
// config     cfg_we, cfg_wdata         rising edge with cfg_we high
//
// An operation token walks the row of slot cells, one cell per cycle, from the
// launch register through each cell's register to the done and result registers.
// busy stays high until the cycle in which done is shown; a new command can
// be taken in that cycle, but not while an earlier command is in the row.
// Reset empties every slot and sets the no-tool code to 255.
// The receiver cannot stall: each result is shown for one cycle only.
module unique_key_slot_table #(
    parameter int SLOTS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  ukst_pkg::ukst_in_t  cmd,
    output logic                done,
    output ukst_pkg::ukst_out_t result,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata
);
    import ukst_pkg::*;

    localparam logic [4:0] SLOT_LIMIT = SLOTS[4:0];

    logic        busy_reg, busy_next;
    logic        done_reg;
    logic [7:0]  ntc_reg;
    logic        launch_valid_reg;
    ukst_tok_t   launch_reg, launch_next;
    ukst_out_t   result_reg, result_next;
    logic        accept;
    logic        tok_valid [SLOTS+1];
    ukst_tok_t   tok       [SLOTS+1];
    ukst_tok_t   last_tok;

    assign accept = start && !busy_reg;

    // Build the token from the command
    always_comb
    begin
        launch_next           = '0;
        launch_next.op        = cmd.op;
        launch_next.slot      = cmd.slot;
        launch_next.key       = cmd.tool_key;
        launch_next.target    = cmd.target_temp;
        launch_next.in_range  = ({1'b0, cmd.slot} < SLOT_LIMIT);
    end

    // Hold the no-tool code
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ntc_reg <= KEY_RESET;
        end
        else if (cfg_we)
        begin
            ntc_reg <= cfg_wdata;
        end
    end

    // Track the operation in flight
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tok_valid[SLOTS])
        begin
            busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg         <= 1'b0;
            launch_valid_reg <= 1'b0;
            done_reg         <= 1'b0;
        end
        else
        begin
            busy_reg         <= busy_next;
            launch_valid_reg <= accept;
            done_reg         <= tok_valid[SLOTS];
        end
    end

    // Latch the token at the head of the row
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            launch_reg <= launch_next;
        end
    end

    assign tok_valid[0] = launch_valid_reg;
    assign tok[0]       = launch_reg;

    // Row of slot cells
    for (genvar i = 0; i < SLOTS; i++)
    begin : g_cell
        ukst_cell #(
            .INDEX(i)
        ) u_cell (
            .clk           (clk),
            .rst_n         (rst_n),
            .no_tool_code  (ntc_reg),
            .tok_valid_in  (tok_valid[i]),
            .tok_in        (tok[i]),
            .tok_valid_out (tok_valid[i+1]),
            .tok_out       (tok[i+1])
        );
    end

    assign last_tok = tok[SLOTS];

    // Form the result from the token leaving the row
    always_comb
    begin
        result_next               = '0;
        if ((last_tok.op == OP_ASSIGN) || (last_tok.op == OP_READ))
        begin
            result_next.ok = last_tok.in_range;
        end
        else
        begin
            result_next.ok = last_tok.found;
        end
        result_next.slot_index    = last_tok.where_idx;
        result_next.slot_occupied = last_tok.socc;
        result_next.slot_key      = last_tok.skey;
        result_next.slot_target   = last_tok.stgt;
        result_next.occupied_count =
            (last_tok.count > COUNT_MAX) ? COUNT_MAX[3:0] : last_tok.count[3:0];
    end

    always_ff @(posedge clk)
    begin
        if (tok_valid[SLOTS])
        begin
            result_reg <= result_next;
        end
    end

    assign busy   = busy_reg;
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// File: src/ukst_cell.sv
module ukst_cell #(
    parameter int INDEX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       no_tool_code,
    input  logic             tok_valid_in,
    input  ukst_pkg::ukst_tok_t tok_in,
    output logic             tok_valid_out,
    output ukst_pkg::ukst_tok_t tok_out
);
    import ukst_pkg::*;

    localparam logic [3:0] IDX = INDEX[3:0];

    logic        occ_reg, occ_next;
    logic [7:0]  key_reg, key_next;
    logic [15:0] tgt_reg, tgt_next;
    logic        valid_reg;
    ukst_tok_t   tok_reg, tok_next;
    logic        key_present;
    logic        match;
    logic        is_slot;

    // Compare this slot against the token
    assign key_present = (tok_in.key != no_tool_code);
    assign match       = occ_reg && (key_reg == tok_in.key) && key_present;
    assign is_slot     = tok_in.in_range && (tok_in.slot == IDX);

    // Apply the operation to this slot and update the token
    always_comb
    begin
        occ_next = occ_reg;
        key_next = key_reg;
        tgt_next = tgt_reg;
        tok_next = tok_in;
        case (tok_in.op)
            OP_ASSIGN:
            begin
                if (is_slot)
                begin
                    occ_next = key_present;
                    key_next = key_present ? tok_in.key : no_tool_code;
                    tgt_next = '0;
                end
                else if (tok_in.in_range && match)
                begin
                    occ_next = 1'b0;
                    key_next = no_tool_code;
                    tgt_next = '0;
                end
            end
            OP_READ:
            begin
                if (is_slot)
                begin
                    tok_next.socc = occ_reg;
                    tok_next.skey = key_reg;
                    tok_next.stgt = tgt_reg;
                end
            end
            OP_FIND:
            begin
                if (match && !tok_in.found)
                begin
                    tok_next.found     = 1'b1;
                    tok_next.where_idx = IDX;
                end
            end
            OP_SET:
            begin
                if (match && !tok_in.found)
                begin
                    tok_next.found     = 1'b1;
                    tok_next.where_idx = IDX;
                    tgt_next           = tok_in.target;
                end
            end
            default:
            begin
                tok_next = tok_in;
            end
        endcase
        tok_next.count = tok_in.count + {4'd0, occ_next};
    end

    // Hold slot contents; change them only while the token sits here
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg   <= 1'b0;
            key_reg   <= KEY_RESET;
            tgt_reg   <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= tok_valid_in;
            if (tok_valid_in)
            begin
                occ_reg <= occ_next;
                key_reg <= key_next;
                tgt_reg <= tgt_next;
            end
        end
    end

    // Pass the token to the next cell
    always_ff @(posedge clk)
    begin
        if (tok_valid_in)
        begin
            tok_reg <= tok_next;
        end
    end

    assign tok_valid_out = valid_reg;
    assign tok_out       = tok_reg;

endmodule
